/* design/kwdt_pkg.sv */
`default_nettype none

package kwdt_pkg;

	// command codes
	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2
	} kwdt_cmd_t;

	// register map
	typedef enum logic [2:0] {
		REG_MATCH  = 3'd0,
		REG_ENABLE = 3'd1,
		REG_CLEAR  = 3'd2,
		REG_STATUS = 3'd3,
		REG_KEY1   = 3'd4,
		REG_KEY2   = 3'd5,
		REG_COUNT  = 3'd6
	} kwdt_reg_t;

	localparam logic [15:0] KEY_FIRST  = 16'hbaba;
	localparam logic [15:0] KEY_SECOND = 16'heb10;

	typedef struct packed {
		logic [15:0] write_data;
		kwdt_reg_t   register_index;
		kwdt_cmd_t   command;
	} kwdt_item_t;

	typedef struct packed {
		logic        write_accepted;
		logic        reset_pulse;
		logic [15:0] read_data;
	} kwdt_result_t;

endpackage

`default_nettype wire

/* design/kwdt_core.sv */
`default_nettype none

module kwdt_core import kwdt_pkg::*; #(
	parameter int COUNTER_WIDTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire kwdt_item_t   item,
	output kwdt_result_t      result
);

	typedef enum logic [1:0] {
		UNLOCK_LOCKED = 2'd0,
		UNLOCK_FIRST  = 2'd1,
		UNLOCK_OPEN   = 2'd2
	} unlock_t;

	logic [COUNTER_WIDTH-1:0] count_q, count_nxt;
	logic [COUNTER_WIDTH-1:0] match_q, match_nxt;
	logic [COUNTER_WIDTH-1:0] count_inc;
	logic                     count_en_q, count_en_nxt;
	logic                     reset_en_q, reset_en_nxt;
	logic                     fired_q, fired_nxt;
	unlock_t                  unlock_q, unlock_nxt;

	logic [COUNTER_WIDTH+15:0] data_ext;
	logic [COUNTER_WIDTH+15:0] count_ext;
	logic [COUNTER_WIDTH+15:0] match_ext;

	assign count_inc = count_q + {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};
	assign data_ext  = {{COUNTER_WIDTH{1'b0}}, item.write_data};
	assign count_ext = {16'b0, count_q};
	assign match_ext = {16'b0, match_q};

	always_comb begin
		count_nxt    = count_q;
		match_nxt    = match_q;
		count_en_nxt = count_en_q;
		reset_en_nxt = reset_en_q;
		fired_nxt    = fired_q;
		unlock_nxt   = unlock_q;
		result       = '0;
		unique case (item.command)
			CMD_TICK: begin
				if (count_en_q) begin
					if (count_inc == match_q) begin
						count_nxt          = '0;
						fired_nxt          = 1'b1;
						result.reset_pulse = reset_en_q;
					end else begin
						count_nxt = count_inc;
					end
				end
			end
			CMD_WRITE: begin
				// any write drops the unlock unless it advances it below
				unlock_nxt = UNLOCK_LOCKED;
				unique case (item.register_index)
					REG_MATCH: begin
						if (unlock_q == UNLOCK_OPEN) begin
							match_nxt             = data_ext[COUNTER_WIDTH-1:0];
							result.write_accepted = 1'b1;
						end
					end
					REG_ENABLE: begin
						if (unlock_q == UNLOCK_OPEN) begin
							count_en_nxt          = item.write_data[0];
							reset_en_nxt          = item.write_data[1];
							result.write_accepted = 1'b1;
						end
					end
					REG_CLEAR: begin
						if (unlock_q == UNLOCK_OPEN) begin
							count_nxt             = '0;
							result.write_accepted = 1'b1;
						end
					end
					REG_KEY1: begin
						if (item.write_data == KEY_FIRST) begin
							unlock_nxt            = UNLOCK_FIRST;
							result.write_accepted = 1'b1;
						end
					end
					REG_KEY2: begin
						if (unlock_q == UNLOCK_FIRST && item.write_data == KEY_SECOND) begin
							unlock_nxt            = UNLOCK_OPEN;
							result.write_accepted = 1'b1;
						end
					end
					default: ;
				endcase
			end
			CMD_READ: begin
				unique case (item.register_index)
					REG_MATCH:  result.read_data = match_ext[15:0];
					REG_ENABLE: result.read_data = {14'b0, reset_en_q, count_en_q};
					REG_STATUS: result.read_data = {15'b0, fired_q};
					REG_COUNT:  result.read_data = count_ext[15:0];
					default:    result.read_data = '0;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			match_q    <= '1;
			count_en_q <= 1'b0;
			reset_en_q <= 1'b0;
			fired_q    <= 1'b0;
			unlock_q   <= UNLOCK_LOCKED;
		end else if (step) begin
			count_q    <= count_nxt;
			match_q    <= match_nxt;
			count_en_q <= count_en_nxt;
			reset_en_q <= reset_en_nxt;
			fired_q    <= fired_nxt;
			unlock_q   <= unlock_nxt;
		end
	end

	// reads and ticks leave the unlock tracker alone
	a_unlock_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.command != CMD_WRITE |=> $stable(unlock_q))
		else $error("unlock stage changed on a non-write transaction");

	// fired flag is sticky
	a_fired_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fired_q |=> fired_q)
		else $error("fired flag cleared");

	// a reset pulse only comes from an enabled counter with reset generation on
	a_pulse_src: assert property (@(posedge clk) disable iff (!arst_n)
		result.reset_pulse |-> item.command == CMD_TICK && count_en_q && reset_en_q)
		else $error("reset pulse without enabled reset generation");

	// a protected write that lands always consumes the unlock
	a_unlock_used: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.write_accepted && item.register_index != REG_KEY1
			&& item.register_index != REG_KEY2
		|-> $past(1'b1) && unlock_q == UNLOCK_OPEN ##1 unlock_q == UNLOCK_LOCKED)
		else $error("protected write accepted without full unlock");

endmodule

`default_nettype wire

/* design/keyed_watchdog_timer_top.sv */
`default_nettype none

// Keyed watchdog timer. Each input transaction is a watchdog tick, a register write or a
// register read (command in s_tuser); each one gives exactly one result transaction
// carrying read data, a reset pulse flag and a write-accepted flag. Writes to match,
// enable and counter clear only land right after key 0xbaba went to the first key
// register and then key 0xeb10 to the second; every protected write needs its own key
// pair and any other write cancels a pending unlock. Throughput is one transaction per
// cycle: the whole step is one increment, one compare and a register update between
// the input register and the output register. An accepted input transaction is held
// in the input register, and its result is written to the output register when the
// step takes place. While a result waits on a stalled master side, an empty input
// register still takes one transaction; once it holds one, s_tready drops in every
// stalled cycle, so input is held off for as long as the master side stalls.
module keyed_watchdog_timer_top import kwdt_pkg::*; #(
	parameter int COUNTER_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [2:0] register_index, [18:3] write_data
	input  wire logic [1:0]  s_tuser,   // [1:0] command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata    // [15:0] read_data, [16] reset_pulse, [17] write_accepted
);

	kwdt_item_t   item_s1;
	logic         valid_s1;
	kwdt_result_t result_c;
	kwdt_result_t result_q;
	logic         out_valid_q;
	logic         advance;
	logic         step;

	// output register is free when empty or being drained this cycle
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.command        <= kwdt_cmd_t'(s_tuser[1:0]);
			item_s1.register_index <= kwdt_reg_t'(s_tdata[2:0]);
			item_s1.write_data     <= s_tdata[18:3];
		end
	end

	// watchdog state and per-transaction step logic
	kwdt_core #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.result (result_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, result_q};

endmodule

`default_nettype wire
